>>> rtl/tmvmm_pkg.sv
// Shared types and constants for the mean / variance / min / max block.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package tmvmm_pkg;

	localparam int BUFFER_DEPTH = 1024;

	localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
	localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
	localparam int SUM_W   = 16 + ADDR_W;
	localparam int DEV_W   = 32 + ADDR_W;
	localparam int STEP_W  = $clog2(DEV_W);
	localparam int TOTAL_W = 11;
	localparam int VAR_W   = 31;

	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic [DEV_W-1:0]   VAR_LIMIT  = DEV_W'(64'd1073741824);

	typedef struct packed {
		logic signed [15:0] sample;
		logic               has_sample;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [15:0]  mean_value;
		logic [VAR_W-1:0]    variance_value;
		logic signed [15:0]  largest;
		logic signed [15:0]  smallest;
		logic [TOTAL_W-1:0]  element_total;
		logic                empty_set;
		logic                overflowed;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/tensor_mean_variance_min_max.sv
// Population mean, variance, min and max over a stored data set.
// Samples load one per cycle with busy low. After the last beat of a non-empty set the block
//   is busy while one shared restoring divider (one quotient bit per cycle over a DEV_W-bit
//   dividend, DEV_W = 42 at depth 1024) runs twice, around a one-element-per-cycle pass over
//   the sample memory. An empty set reports in the cycle after its last beat.
// Reset: asynchronous, active low; clears the set state, no memory clearing pass.
// The result strobe is a single cycle; the receiver cannot stall it.
`default_nettype none

module tensor_mean_variance_min_max (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire tmvmm_pkg::item_t item,
	output logic                done,
	output tmvmm_pkg::result_t  result
);
	import tmvmm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MDIV  = 3'd1;
	localparam logic [2:0] S_PASS  = 3'd2;
	localparam logic [2:0] S_VLOAD = 3'd3;
	localparam logic [2:0] S_VDIV  = 3'd4;

	logic [2:0] state_q;

	// set state
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [15:0]       max_q;
	logic signed [15:0]       min_q;
	logic                     ovf_q;
	logic [DEV_W-1:0]         dev_q;
	logic signed [15:0]       mean_q;
	logic                     neg_q;

	// shared divider
	logic [CNT_W-1:0]  div_rem_q;
	logic [DEV_W-1:0]  div_quo_q;
	logic [STEP_W-1:0] div_cnt_q;

	// second pass pipeline
	logic [CNT_W-1:0]   idx_q;
	logic signed [15:0] rd_data_s1;
	logic               rd_v_s1;
	logic [31:0]        sq_s2;
	logic               sq_v_s2;

	logic               done_q;
	result_t            result_q;

	logic signed [15:0] mem [BUFFER_DEPTH];

	logic                    accept;
	logic                    full;
	logic                    take;
	logic [CNT_W-1:0]        cnt_nx;
	logic signed [SUM_W-1:0] sum_nx;
	logic [SUM_W-1:0]        sum_abs;
	logic signed [15:0]      max_nx;
	logic signed [15:0]      min_nx;
	logic [CNT_W:0]          rem_sh;
	logic                    ge;
	logic [CNT_W-1:0]        rem_new;
	logic [DEV_W-1:0]        quo_new;
	logic [15:0]             q16;
	logic                    issue;
	logic signed [16:0]      diff;
	logic signed [33:0]      prod;
	logic [VAR_W-1:0]        var_sat;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		accept  = start && !busy;
		full    = (count_q == CNT_W'(BUFFER_DEPTH));
		take    = accept && item.has_sample && !full;
		cnt_nx  = count_q + CNT_W'(take);
		sum_nx  = take ? sum_q + SUM_W'(item.sample) : sum_q;
		sum_abs = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);
		max_nx  = (take && item.sample > max_q) ? item.sample : max_q;
		min_nx  = (take && item.sample < min_q) ? item.sample : min_q;

		// one restoring step: remainder stays below the count
		rem_sh  = {div_rem_q, div_quo_q[DEV_W-1]};
		ge      = (rem_sh >= {1'b0, count_q});
		rem_new = ge ? CNT_W'(rem_sh - {1'b0, count_q}) : rem_sh[CNT_W-1:0];
		quo_new = {div_quo_q[DEV_W-2:0], ge};
		q16     = quo_new[15:0];

		issue   = (idx_q != count_q);
		diff    = 17'(rd_data_s1) - 17'(mean_q);
		prod    = diff * diff;
		var_sat = (quo_new > VAR_LIMIT) ? VAR_W'(VAR_LIMIT) : quo_new[VAR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mem[count_q[ADDR_W-1:0]] <= item.sample;
		end
		rd_data_s1 <= mem[idx_q[ADDR_W-1:0]];
		sq_s2      <= prod[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			sum_q     <= '0;
			max_q     <= SAMPLE_MIN;
			min_q     <= SAMPLE_MAX;
			ovf_q     <= 1'b0;
			dev_q     <= '0;
			mean_q    <= '0;
			neg_q     <= 1'b0;
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_cnt_q <= '0;
			idx_q     <= '0;
			rd_v_s1   <= 1'b0;
			sq_v_s2   <= 1'b0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
			sq_v_s2 <= rd_v_s1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= cnt_nx;
						sum_q   <= sum_nx;
						max_q   <= max_nx;
						min_q   <= min_nx;
						if (accept && item.has_sample && full) begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							if (cnt_nx == '0) begin
								// empty set: report now and start over
								done_q                  <= 1'b1;
								result_q.mean_value     <= '0;
								result_q.variance_value <= '0;
								result_q.largest        <= SAMPLE_MIN;
								result_q.smallest       <= SAMPLE_MAX;
								result_q.element_total  <= '0;
								result_q.empty_set      <= 1'b1;
								result_q.overflowed     <= ovf_q;
								count_q <= '0;
								sum_q   <= '0;
								max_q   <= SAMPLE_MIN;
								min_q   <= SAMPLE_MAX;
								ovf_q   <= 1'b0;
								dev_q   <= '0;
							end else begin
								div_rem_q <= '0;
								div_quo_q <= DEV_W'(sum_abs);
								div_cnt_q <= STEP_W'(DEV_W - 1);
								neg_q     <= sum_nx[SUM_W-1];
								state_q   <= S_MDIV;
							end
						end
					end
				end
				S_MDIV: begin
					div_rem_q <= rem_new;
					div_quo_q <= quo_new;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						mean_q  <= neg_q ? -$signed(q16) : $signed(q16);
						idx_q   <= '0;
						dev_q   <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					if (issue) begin
						idx_q   <= idx_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end
					if (sq_v_s2) begin
						dev_q <= dev_q + DEV_W'(sq_s2);
					end
					if (!issue && !rd_v_s1 && !sq_v_s2) begin
						state_q <= S_VLOAD;
					end
				end
				S_VLOAD: begin
					div_rem_q <= '0;
					div_quo_q <= dev_q;
					div_cnt_q <= STEP_W'(DEV_W - 1);
					state_q   <= S_VDIV;
				end
				S_VDIV: begin
					div_rem_q <= rem_new;
					div_quo_q <= quo_new;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						done_q                  <= 1'b1;
						result_q.mean_value     <= mean_q;
						result_q.variance_value <= var_sat;
						result_q.largest        <= max_q;
						result_q.smallest       <= min_q;
						result_q.element_total  <= TOTAL_W'(count_q);
						result_q.empty_set      <= 1'b0;
						result_q.overflowed     <= ovf_q;
						count_q <= '0;
						sum_q   <= '0;
						max_q   <= SAMPLE_MIN;
						min_q   <= SAMPLE_MAX;
						ovf_q   <= 1'b0;
						dev_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/tmvmm_checker.sv
// Port-level checker for the mean / variance / min / max block, bound to the top level.
// Depends on tmvmm_pkg.
`default_nettype none

module tmvmm_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 start,
	input wire                 busy,
	input wire tmvmm_pkg::item_t item,
	input wire                 done,
	input tmvmm_pkg::result_t  result
);
	import tmvmm_pkg::*;

	// a result beat follows either a busy stretch or a closing beat offered with start high
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start && item.last))
		else $error("result without a closed set");

	// leaving the busy stretch always delivers the result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.empty_set |->
			result.mean_value == 16'sd0 && result.variance_value == '0 &&
			result.element_total == '0)
		else $error("empty set result not zeroed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.empty_set |->
			$signed(result.smallest) <= $signed(result.mean_value) &&
			$signed(result.mean_value) <= $signed(result.largest))
		else $error("mean outside the extremes");

	a_var_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.variance_value <= VAR_W'(VAR_LIMIT))
		else $error("variance above its limit");

endmodule

bind tensor_mean_variance_min_max tmvmm_checker u_tmvmm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire

>>> test/tmvmm_checker.sv
`timescale 1ns / 100ps
// Checker for the mean / variance / min / max block: tracks every accepted beat,
// predicts each set's statistics and compares results field by field.
// Depends on tmvmm_pkg only.

module tmvmm_scoreboard (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 busy,
	input  tmvmm_pkg::item_t    item,
	input  wire                 done,
	input  tmvmm_pkg::result_t  result,
	output int                  errors,
	output int                  pending
);
	import tmvmm_pkg::*;

	logic signed [15:0] set_mem [BUFFER_DEPTH];
	int unsigned        set_count;
	longint             set_sum;
	logic signed [15:0] set_max;
	logic signed [15:0] set_min;
	bit                 set_dropped;
	result_t            expected_stats[$];
	result_t            want;

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic clear_set();
		set_count = 0;
		set_sum = 0;
		set_max = SAMPLE_MIN;
		set_min = SAMPLE_MAX;
		set_dropped = 1'b0;
	endtask

	task automatic absorb_beat(input item_t it);
		if (it.has_sample) begin
			if (set_count < BUFFER_DEPTH) begin
				set_mem[ADDR_W'(set_count)] = it.sample;
				set_count++;
				set_sum += it.sample;
				if (it.sample > set_max)
					set_max = it.sample;
				if (it.sample < set_min)
					set_min = it.sample;
			end else begin
				set_dropped = 1'b1;
			end
		end
	endtask

	function automatic result_t set_statistics();
		result_t r;
		longint  mean_q;
		longint  dev_sum;
		longint  var_q;
		longint  d;
		mean_q = 0;
		var_q = 0;
		if (set_count > 0) begin
			// signed longint division truncates toward zero
			mean_q = set_sum / longint'(set_count);
			dev_sum = 0;
			for (int i = 0; i < set_count; i++) begin
				d = longint'(set_mem[ADDR_W'(i)]) - mean_q;
				dev_sum += d * d;
			end
			var_q = dev_sum / longint'(set_count);
			if (var_q > 64'd1073741824)
				var_q = 64'd1073741824;
		end
		r.mean_value     = 16'(mean_q);
		r.variance_value = VAR_W'(var_q);
		r.largest        = set_max;
		r.smallest       = set_min;
		r.element_total  = TOTAL_W'(set_count);
		r.empty_set      = (set_count == 0);
		r.overflowed     = set_dropped;
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] exp_v,
			input logic signed [63:0] got_v);
		if (got_v !== exp_v) begin
			if (errors < 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			expected_stats.delete();
		end else begin
			// a result can never come from the beat accepted at the same edge
			if (done) begin
				if (expected_stats.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing expected: mean %0d var %0d",
							$time, result.mean_value, result.variance_value);
					errors++;
				end else begin
					want = expected_stats.pop_front();
					check_field("mean_value", want.mean_value, result.mean_value);
					check_field("variance_value", want.variance_value, result.variance_value);
					check_field("largest", want.largest, result.largest);
					check_field("smallest", want.smallest, result.smallest);
					check_field("element_total", want.element_total, result.element_total);
					check_field("empty_set", want.empty_set, result.empty_set);
					check_field("overflowed", want.overflowed, result.overflowed);
				end
			end
			if (start && !busy) begin
				absorb_beat(item);
				if (item.last) begin
					expected_stats.insert(expected_stats.size(), set_statistics());
					clear_set();
				end
			end
		end
		pending = expected_stats.size();
	end

endmodule

>>> test/tensor_mean_variance_min_max_test.sv
`timescale 1ns / 100ps
// Testbench top for the mean / variance / min / max block: drives directed and
// random data sets and gives the verdict. Depends on tmvmm_pkg, tmvmm_scoreboard and the block.

module tensor_mean_variance_min_max_test;
	import tmvmm_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int ITEM_GOAL      = 1250;
	localparam int SET_GOAL       = 20;
	localparam int IDLE_PCT       = 21;
	localparam int DRAIN_CYCLES   = 200;

	localparam int MODE_ANY     = 0;
	localparam int MODE_EXTREME = 1;
	localparam int MODE_CLUSTER = 2;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    done;
	item_t   item;
	result_t result;
	int      errors;
	int      pending;
	int      items_sent;
	int      sets_sent;
	int      quiet_cycles;
	int      idle_pct;

	tensor_mean_variance_min_max u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	tmvmm_scoreboard u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic signed [15:0] s, input logic h, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item <= '{sample: 16'($urandom), has_sample: 1'($urandom), last: 1'($urandom)};
			@(negedge clk);
		end
		start <= 1'b1;
		item <= '{sample: s, has_sample: h, last: l};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		if (h || l)
			items_sent++;
		if (l)
			sets_sent++;
	endtask

	function automatic logic signed [15:0] pick_sample(input int mode,
			input logic signed [15:0] center);
		logic signed [15:0] s;
		s = 16'($urandom);
		case (mode)
			MODE_EXTREME: begin
				case ($urandom_range(5))
					0: s = SAMPLE_MIN;
					1: s = SAMPLE_MAX;
					2: s = 16'sh0000;
					3: s = -16'sh0001;
					4: s = 16'sh0001;
					default: ;
				endcase
			end
			MODE_CLUSTER: s = center + 16'($signed($urandom_range(64)) - 32);
			default: ;
		endcase
		return s;
	endfunction

	task automatic send_set(input int n, input int mode, input bit close_invalid);
		logic signed [15:0] center;
		center = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8)
				send_beat(16'($urandom), 1'b0, 1'b0);
			send_beat(pick_sample(mode, center), 1'b1, (i == n - 1) && !close_invalid);
		end
		if (close_invalid || n == 0)
			send_beat(16'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int set_no;
		int r;
		int n;
		bit did_full;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_pct = IDLE_PCT;
		items_sent = 0;
		sets_sent = 0;
		set_no = 0;
		did_full = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty set, then an ignored beat ahead of single-element sets at both extremes
		send_beat(16'sh0000, 1'b0, 1'b1);
		send_beat(16'sh1234, 1'b0, 1'b0);
		send_beat(SAMPLE_MIN, 1'b1, 1'b1);
		send_beat(SAMPLE_MAX, 1'b1, 1'b1);
		// alternating extremes give the largest variance
		for (int i = 0; i < 4; i++)
			send_beat(i % 2 ? SAMPLE_MAX : SAMPLE_MIN, 1'b1, i == 3);
		// filled set closed by a beat with no sample
		send_beat(16'sh0100, 1'b1, 1'b0);
		send_beat(-16'sh0080, 1'b1, 1'b0);
		send_beat(16'sh0001, 1'b1, 1'b0);
		send_beat(16'sh0000, 1'b0, 1'b1);
		// negative mean must truncate toward zero
		send_beat(-16'sh0003, 1'b1, 1'b0);
		send_beat(-16'sh0002, 1'b1, 1'b0);
		send_beat(-16'sh0002, 1'b1, 1'b1);
		send_beat(16'shffff, 1'b1, 1'b0);
		send_beat(16'sh5555, 1'b1, 1'b0);
		send_beat(16'shaaaa, 1'b1, 1'b1);
		// empty set after an ignored beat
		send_beat(16'sh0000, 1'b0, 1'b0);
		send_beat(SAMPLE_MAX, 1'b0, 1'b1);

		while (items_sent < ITEM_GOAL || sets_sent < SET_GOAL) begin
			set_no++;
			idle_pct = (set_no >= 3 && set_no < 11) ? 0 : IDLE_PCT;
			if (!did_full && items_sent >= 200) begin
				// one set runs past the store size so samples get dropped
				did_full = 1'b1;
				send_set(BUFFER_DEPTH + $urandom_range(4, 1), MODE_ANY,
					$urandom_range(1) != 0);
			end else begin
				r = $urandom_range(99);
				if (r < 5)
					n = 0;
				else if (r < 80)
					n = $urandom_range(12, 1);
				else
					n = $urandom_range(80, 13);
				send_set(n, $urandom_range(MODE_CLUSTER), $urandom_range(99) < 15);
			end
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
